FILE: hw/rtl/rbm_pkg.sv
package rbm_pkg;

    localparam int MAX_VISIBLE = 64;
    localparam int MAX_HIDDEN  = 64;
    localparam int WEIGHT_BITS = 16;

    // width of the count registers and of the row counters
    localparam int COUNT_W = 7;
    localparam int VEC_W   = 64;

    // request kinds carried in tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_RUN   = 1'b1;

    typedef struct packed {
        logic rd_en;
        logic acc_clr;
        logic acc_en;
    } lane_ctl_t;

endpackage

FILE: hw/rtl/rbm_ram.sv
module rbm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/rbm_lane.sv
module rbm_lane #(
    parameter int MAX_VISIBLE = rbm_pkg::MAX_VISIBLE,
    parameter int WEIGHT_BITS = rbm_pkg::WEIGHT_BITS,
    parameter int ACC_W       = 23
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rbm_pkg::lane_ctl_t             ctl,
    input  logic                           wr_en,
    input  logic [$clog2(MAX_VISIBLE)-1:0] wr_addr,
    input  logic [WEIGHT_BITS-1:0]         wr_data,
    input  logic [$clog2(MAX_VISIBLE)-1:0] rd_addr,
    input  logic                           neg,
    input  logic                           zero,
    output logic signed [ACC_W-1:0]        term,
    output logic                           acc_negative
);

    logic [WEIGHT_BITS-1:0]  weight;
    logic signed [ACC_W-1:0] weight_ext;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    rbm_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_VISIBLE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (weight)
    );

    assign weight_ext = ACC_W'(signed'(weight));

    always_comb
    begin
        if (zero)
        begin
            term = '0;
        end
        else if (neg)
        begin
            term = -weight_ext;
        end
        else
        begin
            term = weight_ext;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (ctl.acc_en)
        begin
            acc_next = acc_reg + term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc_negative = acc_reg[ACC_W-1];

endmodule

FILE: hw/rtl/rbm_merge.sv
module rbm_merge #(
    parameter int LANES = rbm_pkg::MAX_HIDDEN,
    parameter int ACC_W = 23
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic signed [ACC_W-1:0] terms [LANES],
    output logic                    sum_valid,
    output logic                    sum_negative
);

    localparam int LEVELS = $clog2(LANES);
    localparam int LEAVES = 1 << LEVELS;

    logic signed [ACC_W-1:0] leaf [LEAVES];
    logic signed [ACC_W-1:0] node_reg [LEAVES-1];
    logic [LEVELS-1:0]       valid_reg;

    genvar k;
    generate
        for (k = 0; k < LEAVES; k++)
        begin : g_leaf
            if (k < LANES)
            begin : g_used
                assign leaf[k] = terms[k];
            end
            else
            begin : g_pad
                assign leaf[k] = '0;
            end
        end
        // heap order: children of node k are 2k+1 and 2k+2, leaves follow the nodes
        for (k = 0; k < LEAVES - 1; k++)
        begin : g_node
            if (2 * k + 1 >= LEAVES - 1)
            begin : g_bottom
                always_ff @(posedge clk)
                begin
                    node_reg[k] <= leaf[2 * k + 1 - (LEAVES - 1)]
                                 + leaf[2 * k + 2 - (LEAVES - 1)];
                end
            end
            else
            begin : g_inner
                always_ff @(posedge clk)
                begin
                    node_reg[k] <= node_reg[2 * k + 1] + node_reg[2 * k + 2];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= LEVELS'({valid_reg, in_valid});
        end
    end

    assign sum_valid    = valid_reg[LEVELS-1];
    assign sum_negative = node_reg[0][ACC_W-1];

endmodule

FILE: hw/rtl/bipolar_rbm_inference.sv
// write transaction: taken when idle
// run transaction: each iteration is a hidden pass (row reads into
//   the column lanes) followed by a visible pass (adder tree)
// one run at a time; zero iterations returns an error result
// after reset a clearing pass over all MAX_VISIBLE rows zeroes the weights, no transaction taken
// counts reset to 64, vectors to zero
module bipolar_rbm_inference #(
    parameter int MAX_VISIBLE = rbm_pkg::MAX_VISIBLE,
    parameter int MAX_HIDDEN  = rbm_pkg::MAX_HIDDEN,
    parameter int WEIGHT_BITS = rbm_pkg::WEIGHT_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // weight_row, weight_col, weight_value, visible_in, iterations, zero pad
    input  logic [103:0] s_tdata,
    // req_type
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // visible_out, hidden_out
    output logic [127:0] m_tdata,
    // run_error
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int RA     = $clog2(MAX_VISIBLE);
    localparam int MAXN   = (MAX_VISIBLE > MAX_HIDDEN) ? MAX_VISIBLE : MAX_HIDDEN;
    localparam int ACC_W  = WEIGHT_BITS + $clog2(MAXN) + 1;
    localparam int CW     = rbm_pkg::COUNT_W;
    localparam int VW     = rbm_pkg::VEC_W;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HID   = 3'd2;
    localparam logic [2:0] ST_HWAIT = 3'd3;
    localparam logic [2:0] ST_HCAP  = 3'd4;
    localparam logic [2:0] ST_VIS   = 3'd5;
    localparam logic [2:0] ST_VWAIT = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    localparam logic REQ_WRITE = rbm_pkg::REQ_WRITE;

    // input fields
    logic [5:0]  weight_row;
    logic [5:0]  weight_col;
    logic [15:0] weight_value;
    logic [63:0] visible_in;
    logic [7:0]  iterations;

    assign weight_row   = s_tdata[5:0];
    assign weight_col   = s_tdata[11:6];
    assign weight_value = s_tdata[27:12];
    assign visible_in   = s_tdata[91:28];
    assign iterations   = s_tdata[99:92];

    // configuration
    logic [CW-1:0] vis_cfg_reg, vis_cfg_next;
    logic [CW-1:0] hid_cfg_reg, hid_cfg_next;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? 32'(hid_cfg_reg) : 32'(vis_cfg_reg);

    always_comb
    begin
        vis_cfg_next = vis_cfg_reg;
        hid_cfg_next = hid_cfg_reg;
        if (cfg_wr)
        begin
            if (paddr[2])
            begin
                hid_cfg_next = pwdata[CW-1:0];
            end
            else
            begin
                vis_cfg_next = pwdata[CW-1:0];
            end
        end
    end

    logic [CW-1:0] nv;
    logic [CW-1:0] nh;
    logic [VW-1:0] nv_mask;

    always_comb
    begin
        if (vis_cfg_reg == '0)
        begin
            nv = CW'(1);
        end
        else if (vis_cfg_reg > CW'(MAX_VISIBLE))
        begin
            nv = CW'(MAX_VISIBLE);
        end
        else
        begin
            nv = vis_cfg_reg;
        end
        if (hid_cfg_reg == '0)
        begin
            nh = CW'(1);
        end
        else if (hid_cfg_reg > CW'(MAX_HIDDEN))
        begin
            nh = CW'(MAX_HIDDEN);
        end
        else
        begin
            nh = hid_cfg_reg;
        end
        for (int b = 0; b < VW; b++)
        begin
            nv_mask[b] = (CW'(b) < nv);
        end
    end

    // sequencer state
    logic [2:0]     state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  col_cnt_reg, col_cnt_next;
    logic [7:0]     pass_reg, pass_next;
    logic [7:0]     iters_reg, iters_next;
    logic           err_reg, err_next;
    logic [VW-1:0]  visible_reg, visible_next;
    logic [VW-1:0]  vnew_reg, vnew_next;
    logic [MAX_HIDDEN-1:0] hidden_reg, hidden_next;
    logic           rd_v_reg, rd_v_next;
    logic           rd_vis_reg, rd_vis_next;
    logic [MAX_HIDDEN-1:0] neg_reg, neg_next;
    logic [MAX_HIDDEN-1:0] zero_reg, zero_next;
    logic           m_valid_reg, m_valid_next;
    logic [127:0]   m_data_reg, m_data_next;
    logic           m_err_reg, m_err_next;

    // lane wiring
    rbm_pkg::lane_ctl_t    ctl;
    logic [MAX_HIDDEN-1:0] lane_wr;
    logic [RA-1:0]         wr_addr;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic [31:0]           weight_wide;
    logic signed [ACC_W-1:0] terms [MAX_HIDDEN];
    logic [MAX_HIDDEN-1:0] acc_negative;
    logic                  sum_valid;
    logic                  sum_negative;
    logic                  s_accept;
    logic                  wr_in_range;
    logic                  issue;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign weight_wide = {{16{weight_value[15]}}, weight_value};
    assign wr_in_range = ({1'b0, weight_row} < CW'(MAX_VISIBLE))
                      && ({1'b0, weight_col} < CW'(MAX_HIDDEN));
    assign issue       = (state_reg == ST_HID) || (state_reg == ST_VIS);

    always_comb
    begin
        if (state_reg == ST_CLR)
        begin
            wr_addr = cnt_reg[RA-1:0];
            wr_data = '0;
            lane_wr = '1;
        end
        else
        begin
            wr_addr = weight_row[RA-1:0];
            wr_data = weight_wide[WEIGHT_BITS-1:0];
            lane_wr = '0;
            if (s_accept && (s_tuser == REQ_WRITE) && wr_in_range)
            begin
                for (int j = 0; j < MAX_HIDDEN; j++)
                begin
                    lane_wr[j] = ({1'b0, weight_col} == CW'(j));
                end
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        col_cnt_next = col_cnt_reg;
        pass_next    = pass_reg;
        iters_next   = iters_reg;
        err_next     = err_reg;
        visible_next = visible_reg;
        vnew_next    = vnew_reg;
        hidden_next  = hidden_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_err_next   = m_err_reg;
        ctl.rd_en    = issue;
        ctl.acc_clr  = 1'b0;
        ctl.acc_en   = rd_v_reg && !rd_vis_reg;
        rd_v_next    = issue;
        rd_vis_next  = (state_reg == ST_VIS);
        for (int j = 0; j < MAX_HIDDEN; j++)
        begin
            if (state_reg == ST_VIS)
            begin
                neg_next[j]  = !hidden_reg[j];
                zero_next[j] = (CW'(j) >= nh);
            end
            else
            begin
                neg_next[j]  = !visible_reg[cnt_reg[5:0]];
                zero_next[j] = 1'b0;
            end
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        // visible results leave the adder tree in row order
        if (sum_valid)
        begin
            vnew_next[col_cnt_reg[5:0]] = !sum_negative;
            col_cnt_next = col_cnt_reg + CW'(1);
        end

        unique case (state_reg)
            ST_CLR:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MAX_VISIBLE - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept && (s_tuser != REQ_WRITE))
                begin
                    iters_next   = iterations;
                    pass_next    = '0;
                    visible_next = visible_in & nv_mask;
                    cnt_next     = '0;
                    if (iterations == '0)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        err_next    = 1'b0;
                        ctl.acc_clr = 1'b1;
                        state_next  = ST_HID;
                    end
                end
            end
            ST_HID:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == nv - CW'(1))
                begin
                    state_next = ST_HWAIT;
                end
            end
            ST_HWAIT:
            begin
                state_next = ST_HCAP;
            end
            ST_HCAP:
            begin
                for (int j = 0; j < MAX_HIDDEN; j++)
                begin
                    hidden_next[j] = !acc_negative[j] && (CW'(j) < nh);
                end
                cnt_next     = '0;
                col_cnt_next = '0;
                vnew_next    = '0;
                state_next   = ST_VIS;
            end
            ST_VIS:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == nv - CW'(1))
                begin
                    state_next = ST_VWAIT;
                end
            end
            ST_VWAIT:
            begin
                if (col_cnt_reg == nv)
                begin
                    visible_next = vnew_reg;
                    pass_next    = pass_reg + 8'd1;
                    cnt_next     = '0;
                    if (pass_reg == iters_reg - 8'd1)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        ctl.acc_clr = 1'b1;
                        state_next  = ST_HID;
                    end
                end
            end
            ST_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_err_next   = err_reg;
                    if (err_reg)
                    begin
                        m_data_next = '0;
                    end
                    else
                    begin
                        m_data_next = {VW'(hidden_reg), visible_reg & nv_mask};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            cnt_reg     <= '0;
            col_cnt_reg <= '0;
            pass_reg    <= '0;
            iters_reg   <= '0;
            err_reg     <= 1'b0;
            visible_reg <= '0;
            vnew_reg    <= '0;
            hidden_reg  <= '0;
            rd_v_reg    <= 1'b0;
            rd_vis_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            m_err_reg   <= 1'b0;
            vis_cfg_reg <= CW'(64);
            hid_cfg_reg <= CW'(64);
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            col_cnt_reg <= col_cnt_next;
            pass_reg    <= pass_next;
            iters_reg   <= iters_next;
            err_reg     <= err_next;
            visible_reg <= visible_next;
            vnew_reg    <= vnew_next;
            hidden_reg  <= hidden_next;
            rd_v_reg    <= rd_v_next;
            rd_vis_reg  <= rd_vis_next;
            m_valid_reg <= m_valid_next;
            m_err_reg   <= m_err_next;
            vis_cfg_reg <= vis_cfg_next;
            hid_cfg_reg <= hid_cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        m_data_reg <= m_data_next;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_HIDDEN; g++)
        begin : g_lane
            rbm_lane #(
                .MAX_VISIBLE (MAX_VISIBLE),
                .WEIGHT_BITS (WEIGHT_BITS),
                .ACC_W       (ACC_W)
            ) u_lane (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl),
                .wr_en        (lane_wr[g]),
                .wr_addr      (wr_addr),
                .wr_data      (wr_data),
                .rd_addr      (cnt_reg[RA-1:0]),
                .neg          (neg_reg[g]),
                .zero         (zero_reg[g]),
                .term         (terms[g]),
                .acc_negative (acc_negative[g])
            );
        end
    endgenerate

    rbm_merge #(
        .LANES (MAX_HIDDEN),
        .ACC_W (ACC_W)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (rd_v_reg && rd_vis_reg),
        .terms        (terms),
        .sum_valid    (sum_valid),
        .sum_negative (sum_negative)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_err_reg;

endmodule
